// ----- hw/rtl/gnmc_pkg.sv -----
// Shared types, character codes and register indexes for the grid mine counter.
// No dependencies; all files but gnmc_ram refer to it by scoped names.
`default_nettype none

package gnmc_pkg;

	// Configuration registers hold eight-bit grid dimensions.
	localparam int DIM_W     = 8;
	localparam int CFG_IDX_W = 2;

	typedef logic [DIM_W-1:0]     dim_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Register indexes on the configuration port.
	localparam cfg_idx_t REG_WIDTH  = 2'd0;
	localparam cfg_idx_t REG_HEIGHT = 2'd1;

	// Character codes of the grid text.
	localparam logic [7:0] CH_ASK  = 8'h3F;
	localparam logic [7:0] CH_MINE = 8'h2A;
	localparam logic [7:0] CH_ZERO = 8'h30;

	// Per-item control that travels from the sequencer into the evaluate stage.
	typedef struct packed {
		logic emit;
		logic row_end;
		logic frame_end;
		logic mine;
		logic use_up;
		logic use_mid;
	} item_ctl_t;

	// One entry of the mine line store: the two rows above the current input row.
	typedef struct packed {
		logic upper;
		logic middle;
	} mine_pair_t;

	// Out-of-range dimensions are pulled into 1..cap.
	function automatic dim_t clamp_dim(input dim_t v, input dim_t cap);
		dim_t r;
		r = v;
		if (r == '0) begin
			r = dim_t'(1);
		end
		if (r > cap) begin
			r = cap;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gnmc_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// Read-first on a same-address collision. Depends on nothing.
`default_nettype none

module gnmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [(DEPTH>1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [(DEPTH>1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; the read returns the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/gnmc_seq.sv -----
// Input sequencer: configuration registers, raster counters and store addresses.
// Depends on gnmc_pkg for the dimension type, register indexes and control struct.
`default_nettype none

module gnmc_seq #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	input  wire gnmc_pkg::cfg_idx_t      cfg_index,
	input  wire gnmc_pkg::dim_t          cfg_data,
	output logic                         cfg_clear,
	input  wire logic                    accept,
	input  wire logic                    command,
	input  wire logic [7:0]              cell_char,
	output logic [(MAX_WIDTH>1 ? $clog2(MAX_WIDTH) : 1)-1:0] col,
	output logic [$clog2(MAX_WIDTH+1)-1:0] ring_ptr,
	output gnmc_pkg::item_ctl_t          ctl
);

	localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int KW     = $clog2(MAX_WIDTH + 1);
	localparam int WCAP_I = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
	localparam int HCAP_I = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;
	localparam int RW     = $clog2(HCAP_I + 2);
	localparam int CMPW   = (CW + 1 > gnmc_pkg::DIM_W) ? CW + 1 : gnmc_pkg::DIM_W;
	localparam int RCW    = (RW > gnmc_pkg::DIM_W + 1) ? RW : gnmc_pkg::DIM_W + 1;
	localparam int PCW    = (KW > gnmc_pkg::DIM_W) ? KW : gnmc_pkg::DIM_W;
	localparam gnmc_pkg::dim_t WCAP = gnmc_pkg::dim_t'(WCAP_I);
	localparam gnmc_pkg::dim_t HCAP = gnmc_pkg::dim_t'(HCAP_I);

	gnmc_pkg::dim_t width_q, height_q;
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [KW-1:0]  ptr_q;

	logic [CMPW-1:0] col_ext, wid_ext;
	logic [RCW-1:0]  row_ext, hgt_ext;
	logic            col_last, ptr_last, row_ge2, row_eq1, row_lt_h, row_past;
	logic            emit, frame_end, cfg_wr;

	// Position decode for the item now at the input.
	always_comb begin
		col_ext   = CMPW'(col_q);
		wid_ext   = CMPW'(width_q);
		row_ext   = RCW'(row_q);
		hgt_ext   = RCW'(height_q);
		col_last  = (col_ext + CMPW'(1)) >= wid_ext;
		ptr_last  = PCW'(ptr_q) == PCW'(width_q);
		row_ge2   = row_ext >= RCW'(2);
		row_eq1   = row_ext == RCW'(1);
		row_lt_h  = row_ext < hgt_ext;
		row_past  = row_ext == (hgt_ext + RCW'(1));
		emit      = row_ge2 || (row_eq1 && (col_q != '0));
		frame_end = emit && (col_q == '0) && row_past;
	end

	assign cfg_wr    = cfg_valid &&
		((cfg_index == gnmc_pkg::REG_WIDTH) || (cfg_index == gnmc_pkg::REG_HEIGHT));
	assign cfg_clear = cfg_wr;
	assign col       = col_q;
	assign ring_ptr  = ptr_q;

	// Control bits handed to the evaluate stage with the transfer.
	always_comb begin
		ctl.emit      = emit;
		ctl.row_end   = (col_q == '0);
		ctl.frame_end = frame_end;
		ctl.mine      = !command && row_lt_h && (cell_char == gnmc_pkg::CH_MINE);
		ctl.use_up    = row_ge2;
		ctl.use_mid   = (row_q != '0);
	end

	// Registers and raster counters; a register write or the frame end restarts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= gnmc_pkg::dim_t'(1);
			height_q <= gnmc_pkg::dim_t'(1);
			col_q    <= '0;
			row_q    <= '0;
			ptr_q    <= '0;
		end else if (cfg_wr) begin
			if (cfg_index == gnmc_pkg::REG_WIDTH) begin
				width_q <= gnmc_pkg::clamp_dim(cfg_data, WCAP);
			end else begin
				height_q <= gnmc_pkg::clamp_dim(cfg_data, HCAP);
			end
			col_q <= '0;
			row_q <= '0;
			ptr_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
				ptr_q <= '0;
			end else begin
				col_q <= col_last ? '0 : col_q + CW'(1);
				row_q <= col_last ? row_q + RW'(1) : row_q;
				ptr_q <= ptr_last ? '0 : ptr_q + KW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/gnmc_eval.sv -----
// Evaluate stage: mine line write-back with forwarding, 3x3 window, count, result register.
// Depends on gnmc_pkg for the control struct, store entry type and character codes.
`default_nettype none

module gnmc_eval #(
	parameter int MAX_WIDTH = 128
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  clear,
	input  wire logic                  accept,
	input  wire logic [(MAX_WIDTH>1 ? $clog2(MAX_WIDTH) : 1)-1:0] rd_addr,
	input  wire gnmc_pkg::item_ctl_t   ctl_in,
	input  wire gnmc_pkg::mine_pair_t  pair_rdata,
	input  wire logic [7:0]            center,
	output logic                       pair_we,
	output logic [(MAX_WIDTH>1 ? $clog2(MAX_WIDTH) : 1)-1:0] pair_waddr,
	output gnmc_pkg::mine_pair_t       pair_wdata,
	output logic                       take_ok,
	input  wire logic                  res_ready,
	output logic                       res_valid,
	output logic [7:0]                 out_char,
	output logic                       row_end,
	output logic                       frame_end
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic                 s1_valid;
	gnmc_pkg::item_ctl_t  ctl_s1;
	logic [CW-1:0]        addr_s1;
	logic                 fwd_s1;
	gnmc_pkg::mine_pair_t fwd_data_s1;
	logic [8:0]           win_q;

	logic                 s1_adv;
	gnmc_pkg::mine_pair_t pair_old;
	logic                 up, mid;
	logic [2:0]           newcol;
	logic [8:0]           win_next, view, bits;
	logic [3:0]           count;
	logic [7:0]           char_next;

	assign s1_adv  = s1_valid && (!res_valid || res_ready);
	assign take_ok = !s1_valid || s1_adv;

	// A store read that collides with the write-back in the same cycle takes the new word.
	assign pair_old = fwd_s1 ? fwd_data_s1 : pair_rdata;

	// Shift the mine column down one row and write it back.
	always_comb begin
		pair_we           = s1_adv;
		pair_waddr        = addr_s1;
		pair_wdata.upper  = pair_old.middle;
		pair_wdata.middle = ctl_s1.mine;
	end

	// New window column and the view around the result cell.
	always_comb begin
		up     = ctl_s1.use_up && pair_old.upper;
		mid    = ctl_s1.use_mid && pair_old.middle;
		newcol = {ctl_s1.mine, mid, up};
		if (ctl_s1.row_end) begin
			win_next = {newcol, 6'b0};
			view     = {3'b0, win_q[8:3]};
		end else begin
			win_next = {newcol, win_q[8:3]};
			view     = win_next;
		end
		bits  = view & ~9'h010;
		count = '0;
		for (int i = 0; i < 9; i++) begin
			count = count + 4'(bits[i]);
		end
		if (center == gnmc_pkg::CH_ASK) begin
			char_next = gnmc_pkg::CH_ZERO + 8'(count);
		end else begin
			char_next = center;
		end
	end

	// Stage 1 control and forwarding flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
			fwd_s1   <= s1_adv && (addr_s1 == rd_addr);
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1      <= ctl_in;
			addr_s1     <= rd_addr;
			fwd_data_s1 <= pair_wdata;
		end
	end

	// Window register; cleared at frame end and on a register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (clear) begin
			win_q <= '0;
		end else if (s1_adv) begin
			win_q <= ctl_s1.frame_end ? '0 : win_next;
		end
	end

	// Result register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (s1_adv && ctl_s1.emit) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	// Result register: payload.
	always_ff @(posedge clk) begin
		if (s1_adv && ctl_s1.emit) begin
			out_char  <= char_next;
			row_end   <= ctl_s1.row_end;
			frame_end <= ctl_s1.frame_end;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/grid_neighbour_mine_count_top.sv -----
// Top level of the grid mine counter: sequencer, evaluate stage and the two line stores.
// Depends on gnmc_pkg, gnmc_ram, gnmc_seq and gnmc_eval.
`default_nettype none

// Streams a character grid in raster order, one cell per transfer, and returns each
// cell with every '?' replaced by the digit of its neighbouring '*' count; cells
// outside the grid count as empty. A cell is accepted every clock, and a result is
// delivered every clock while res_ready stays high; the figure is set by the single
// read-modify-write of the mine line store per cell, with the write-back forwarded
// when consecutive cells hit the same column. Results trail the input by grid_width+1
// transfers, via the stage 1 and result registers. After the last cell, send
// grid_width+1 items with command set to flush the grid; the result that closes the
// grid carries frame_end. Writing a register restarts the frame; the user must do so
// only while the block is idle (unenforced). The stores need no clearing after reset.
module grid_neighbour_mine_count_top #(
	parameter int MAX_WIDTH  = 128,
	parameter int MAX_HEIGHT = 128
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire gnmc_pkg::cfg_idx_t  cfg_index,
	input  wire gnmc_pkg::dim_t      cfg_data,
	input  wire logic                cell_valid,
	output logic                     cell_ready,
	input  wire logic                command,
	input  wire logic [7:0]          cell_char,
	output logic                     res_valid,
	input  wire logic                res_ready,
	output logic [7:0]               out_char,
	output logic                     row_end,
	output logic                     frame_end
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int KW = $clog2(MAX_WIDTH + 1);

	logic                 accept, cfg_clear, take_ok, pair_we;
	logic [CW-1:0]        col, pair_waddr;
	logic [KW-1:0]        ring_ptr;
	gnmc_pkg::item_ctl_t  ctl;
	gnmc_pkg::mine_pair_t pair_wdata;
	logic [$bits(gnmc_pkg::mine_pair_t)-1:0] pair_rdata;
	logic [7:0]           center, char_wdata;

	assign cfg_ready  = 1'b1;
	assign cell_ready = take_ok;
	assign accept     = cell_valid && cell_ready;
	assign char_wdata = command ? 8'h00 : cell_char;

	gnmc_seq #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_clear (cfg_clear),
		.accept    (accept),
		.command   (command),
		.cell_char (cell_char),
		.col       (col),
		.ring_ptr  (ring_ptr),
		.ctl       (ctl)
	);

	// Mine bits of the two rows above, one entry per column.
	gnmc_ram #(
		.WIDTH ($bits(gnmc_pkg::mine_pair_t)),
		.DEPTH (MAX_WIDTH)
	) u_mine_ram (
		.clk   (clk),
		.we    (pair_we),
		.waddr (pair_waddr),
		.wdata (pair_wdata),
		.re    (accept),
		.raddr (col),
		.rdata (pair_rdata)
	);

	// Ring of cell bytes that delays each byte by grid_width+1 transfers.
	gnmc_ram #(
		.WIDTH (8),
		.DEPTH (MAX_WIDTH + 1)
	) u_char_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (ring_ptr),
		.wdata (char_wdata),
		.re    (accept),
		.raddr (ring_ptr),
		.rdata (center)
	);

	gnmc_eval #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (cfg_clear),
		.accept     (accept),
		.rd_addr    (col),
		.ctl_in     (ctl),
		.pair_rdata (gnmc_pkg::mine_pair_t'(pair_rdata)),
		.center     (center),
		.pair_we    (pair_we),
		.pair_waddr (pair_waddr),
		.pair_wdata (pair_wdata),
		.take_ok    (take_ok),
		.res_ready  (res_ready),
		.res_valid  (res_valid),
		.out_char   (out_char),
		.row_end    (row_end),
		.frame_end  (frame_end)
	);

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for grid_neighbour_mine_count_top: streams character grids with
// random handshake pacing and checks every result transfer against a cycle-free predictor.
// Depends on gnmc_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb;

	localparam int MAX_W = 128;
	localparam int MAX_H = 128;

	// Item commands on the cell channel.
	localparam logic CMD_CELL  = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// Register indexes that address no register.
	localparam gnmc_pkg::cfg_idx_t REG_SPARE_A = 2'd2;
	localparam gnmc_pkg::cfg_idx_t REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [7:0] char_out;
		logic       row_last;
		logic       grid_last;
	} cell_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	gnmc_pkg::cfg_idx_t cfg_index;
	gnmc_pkg::dim_t     cfg_data;
	logic               cell_valid;
	logic               cell_ready;
	logic               command;
	logic [7:0]         cell_char;
	logic               res_valid;
	logic               res_ready;
	logic [7:0]         out_char;
	logic               row_end;
	logic               frame_end;

	// Predictor state: grid size, line stores, window and position counters.
	int unsigned  grid_w;
	int unsigned  grid_h;
	bit           mine_two_up [MAX_W];
	bit           mine_one_up [MAX_W];
	logic [7:0]   char_delay [MAX_W+1];
	logic [8:0]   window;
	int unsigned  in_col;
	int unsigned  in_row;
	int unsigned  out_pos;
	cell_result_t pending_cells [$];

	int mismatch_count;
	int cells_sent;
	int burst_left;

	grid_neighbour_mine_count_top #(
		.MAX_WIDTH  (MAX_W),
		.MAX_HEIGHT (MAX_H)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.command    (command),
		.cell_char  (cell_char),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.out_char   (out_char),
		.row_end    (row_end),
		.frame_end  (frame_end)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A generous bound on the whole run; reaching it means the block hung.
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	// Every write to the width or height register throws away the frame in progress.
	function automatic void restart_counters();
		window  = '0;
		in_col  = 0;
		in_row  = 0;
		out_pos = 0;
	endfunction

	function automatic int unsigned clamp_setting(logic [7:0] v, int unsigned cap);
		int unsigned x;
		x = v;
		if (x == 0) begin
			x = 1;
		end
		if (x > cap) begin
			x = cap;
		end
		return x;
	endfunction

	function automatic void apply_register(gnmc_pkg::cfg_idx_t idx, logic [7:0] v);
		case (idx)
			gnmc_pkg::REG_WIDTH: begin
				grid_w = clamp_setting(v, MAX_W);
				restart_counters();
			end
			gnmc_pkg::REG_HEIGHT: begin
				grid_h = clamp_setting(v, MAX_H);
				restart_counters();
			end
			default: begin
			end
		endcase
	endfunction

	// Advances the predictor by one accepted cell transfer and queues the result it releases.
	function automatic void advance_mine_counter(logic cmd, logic [7:0] ch);
		int unsigned  c;
		int unsigned  r;
		int unsigned  t;
		int unsigned  k;
		logic         is_mine;
		logic         above2;
		logic         above1;
		logic [2:0]   column_bits;
		logic [8:0]   view;
		logic [7:0]   center;
		logic [3:0]   n_mines;
		cell_result_t res;
		c = in_col;
		r = in_row;
		t = r * grid_w + c;
		is_mine = (cmd == CMD_CELL) && (r < grid_h) && (ch == gnmc_pkg::CH_MINE);
		above2 = (r >= 2) ? mine_two_up[c] : 1'b0;
		above1 = (r >= 1) ? mine_one_up[c] : 1'b0;
		mine_two_up[c] = mine_one_up[c];
		mine_one_up[c] = is_mine;
		column_bits = {is_mine, above1, above2};

		// At column zero the released cell is the last of the previous row, so its right
		// column is empty, and the new row starts with an empty left column.
		if (c == 0) begin
			view   = window >> 3;
			window = {column_bits, 6'b0};
		end else begin
			window = {column_bits, window[8:3]};
			view   = window;
		end

		k = t % (grid_w + 1);
		center = char_delay[k];
		char_delay[k] = (cmd == CMD_DRAIN) ? 8'h00 : ch;

		in_col = c + 1;
		if (in_col >= grid_w) begin
			in_col = 0;
			in_row = r + 1;
		end

		if (t >= grid_w + 1) begin
			// The center bit is the cell itself and never counts.
			n_mines = 4'($countones(view & 9'h1EF));
			res.char_out  = (center == gnmc_pkg::CH_ASK) ?
				gnmc_pkg::CH_ZERO + 8'(n_mines) : center;
			res.row_last  = (c == 0);
			res.grid_last = (out_pos >= grid_w * grid_h - 1);
			pending_cells.push_back(res);
			if (res.grid_last) begin
				restart_counters();
			end else begin
				out_pos++;
			end
		end
	endfunction

	// Mines and question marks dominate so that counts of every size appear.
	function automatic logic [7:0] pick_char();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 4) begin
			return gnmc_pkg::CH_MINE;
		end else if (sel < 7) begin
			return gnmc_pkg::CH_ASK;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// Encodes a dimension, sometimes as an out-of-range value that clamps to it.
	function automatic logic [7:0] encode_dim(int unsigned v, int unsigned cap);
		if (v == 1 && $urandom_range(0, 1) == 1) begin
			return 8'h00;
		end
		if (v == cap && $urandom_range(0, 1) == 1) begin
			return 8'($urandom_range(cap + 1, 255));
		end
		return 8'(v);
	endfunction

	// Sends one cell transfer; the sender runs in bursts with random gaps between them.
	task automatic send_cell(logic cmd, logic [7:0] ch);
		cell_valid <= 1'b1;
		command    <= cmd;
		cell_char  <= ch;
		@(posedge clk);
		while (!cell_ready) begin
			@(posedge clk);
		end
		advance_mine_counter(cmd, ch);
		cells_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 30);
			if ($urandom_range(0, 3) != 0) begin
				cell_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	// Holds the sender until every expected result has arrived and the pipeline is empty.
	task automatic wait_for_results();
		cell_valid <= 1'b0;
		while (pending_cells.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	// One transfer on the configuration channel; valid stays high unless this is the last.
	task automatic write_register(gnmc_pkg::cfg_idx_t idx, logic [7:0] data, bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		apply_register(idx, data);
		if (last) begin
			cfg_valid <= 1'b0;
		end
	endtask

	task automatic set_grid(logic [7:0] w_val, logic [7:0] h_val);
		if ($urandom_range(0, 1) == 1) begin
			write_register(gnmc_pkg::REG_WIDTH, w_val, 1'b0);
			write_register(gnmc_pkg::REG_HEIGHT, h_val, 1'b1);
		end else begin
			write_register(gnmc_pkg::REG_HEIGHT, h_val, 1'b0);
			write_register(gnmc_pkg::REG_WIDTH, w_val, 1'b1);
		end
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			send_cell(CMD_CELL, s[i]);
		end
	endtask

	// Flush transfers mix drain ticks with cell items, which count as drains past the grid.
	task automatic send_drains(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 1) == 1) begin
				send_cell(CMD_DRAIN, pick_char());
			end else begin
				send_cell(CMD_CELL, pick_char());
			end
		end
	endtask

	// Random grid cells with an occasional drain tick inside the grid.
	task automatic send_random_cells(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0) begin
				send_cell(CMD_DRAIN, pick_char());
			end else begin
				send_cell(CMD_CELL, pick_char());
			end
		end
	endtask

	task automatic send_random_frame();
		send_random_cells(grid_w * grid_h);
		send_drains(grid_w + 1);
	endtask

	// The size after reset is one by one.
	task automatic test_reset_state();
		send_text("?");
		send_cell(CMD_DRAIN, 8'h00);
		send_cell(CMD_DRAIN, 8'hFF);
		send_cell(CMD_CELL, gnmc_pkg::CH_MINE);
		send_cell(CMD_CELL, gnmc_pkg::CH_MINE);
		send_cell(CMD_DRAIN, gnmc_pkg::CH_ASK);
	endtask

	// Full neighborhood gives eight; corners and edges see only part of it.
	task automatic test_neighbour_counts();
		wait_for_results();
		set_grid(8'd3, 8'd3);
		send_text("****?****");
		send_drains(4);
		send_text("?*?*?*?*?");
		repeat (4) send_cell(CMD_CELL, gnmc_pkg::CH_MINE);
	endtask

	// A drain tick inside the grid is a zero byte that is not a mine.
	task automatic test_drain_inside_grid();
		wait_for_results();
		set_grid(8'd3, 8'd2);
		send_cell(CMD_CELL, gnmc_pkg::CH_MINE);
		send_cell(CMD_DRAIN, gnmc_pkg::CH_MINE);
		send_cell(CMD_CELL, gnmc_pkg::CH_ASK);
		send_cell(CMD_CELL, 8'hFF);
		send_cell(CMD_CELL, gnmc_pkg::CH_ASK);
		send_cell(CMD_CELL, 8'h00);
		send_drains(4);
	endtask

	// Out-of-range values clamp; the largest width and height each get a frame.
	task automatic test_register_limits();
		wait_for_results();
		set_grid(8'd0, 8'd255);
		send_random_frame();
		wait_for_results();
		set_grid(8'd255, 8'd0);
		send_random_frame();
		wait_for_results();
		write_register(gnmc_pkg::REG_WIDTH, 8'd129, 1'b0);
		write_register(gnmc_pkg::REG_HEIGHT, 8'd129, 1'b0);
		write_register(gnmc_pkg::REG_HEIGHT, 8'd2, 1'b1);
		send_random_frame();
		wait_for_results();
		set_grid(8'd1, 8'd1);
		send_random_frame();
	endtask

	// A register write abandons a partial frame; the spare indexes must not.
	task automatic test_frame_restart();
		wait_for_results();
		set_grid(8'd4, 8'd4);
		send_random_cells(9);
		wait_for_results();
		write_register(gnmc_pkg::REG_HEIGHT, 8'd3, 1'b1);
		send_random_frame();
		wait_for_results();
		set_grid(8'd5, 8'd2);
		send_random_cells(7);
		wait_for_results();
		write_register(REG_SPARE_A, 8'($urandom_range(0, 255)), 1'b0);
		write_register(REG_SPARE_B, 8'($urandom_range(0, 255)), 1'b1);
		send_random_cells(3);
		send_drains(6);
	endtask

	// Mostly whole frames of small random size, some back to back, some cut short.
	task automatic test_random_traffic();
		int unsigned target;
		int unsigned w;
		int unsigned h;
		int unsigned pick;
		bit          reconfigure;
		target = 1250;
		reconfigure = 1'b1;
		while (cells_sent < target) begin
			if (reconfigure || $urandom_range(0, 2) == 0) begin
				wait_for_results();
				pick = $urandom_range(0, 14);
				if (pick == 0) begin
					w = $urandom_range(64, MAX_W);
					h = $urandom_range(1, 2);
				end else if (pick == 1) begin
					w = $urandom_range(1, 2);
					h = $urandom_range(64, MAX_H);
				end else begin
					w = $urandom_range(1, 10);
					h = $urandom_range(1, 6);
				end
				if ($urandom_range(0, 5) == 0) begin
					write_register(($urandom_range(0, 1) == 1) ? REG_SPARE_A : REG_SPARE_B,
						8'($urandom_range(0, 255)), 1'b0);
				end
				set_grid(encode_dim(w, MAX_W), encode_dim(h, MAX_H));
				reconfigure = 1'b0;
			end
			if ($urandom_range(0, 9) == 0) begin
				send_random_cells($urandom_range(1, grid_w * grid_h + grid_w));
				reconfigure = 1'b1;
			end else begin
				send_random_frame();
			end
		end
	endtask

	// The receiver stalls on its own pattern, changing mode every stretch.
	initial begin
		int unsigned mode;
		int unsigned span;
		res_ready <= 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			for (int i = 0; i < span; i++) begin
				@(posedge clk);
				case (mode)
					0: res_ready <= 1'b1;
					1: res_ready <= 1'($urandom_range(0, 1));
					2: res_ready <= (i % 4 == 0);
					default: res_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Each result transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		cell_result_t exp_res;
		if (arst_n && res_valid && res_ready) begin
			if (pending_cells.size() == 0) begin
				$error("out_char: no result expected, got %0h", out_char);
				mismatch_count++;
			end else begin
				exp_res = pending_cells.pop_front();
				if (out_char !== exp_res.char_out) begin
					$error("out_char: expected %0h, got %0h", exp_res.char_out, out_char);
					mismatch_count++;
				end
				if (row_end !== exp_res.row_last) begin
					$error("row_end: expected %0b, got %0b", exp_res.row_last, row_end);
					mismatch_count++;
				end
				if (frame_end !== exp_res.grid_last) begin
					$error("frame_end: expected %0b, got %0b", exp_res.grid_last, frame_end);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		grid_w = 1;
		grid_h = 1;
		foreach (mine_two_up[i]) begin
			mine_two_up[i] = 1'b0;
			mine_one_up[i] = 1'b0;
		end
		foreach (char_delay[i]) begin
			char_delay[i] = 8'h00;
		end
		restart_counters();
		mismatch_count = 0;
		cells_sent = 0;
		burst_left = 0;

		arst_n     <= 1'b0;
		cfg_valid  <= 1'b0;
		cfg_index  <= gnmc_pkg::REG_WIDTH;
		cfg_data   <= '0;
		cell_valid <= 1'b0;
		command    <= CMD_CELL;
		cell_char  <= 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_neighbour_counts();
		test_drain_inside_grid();
		test_register_limits();
		test_frame_restart();
		test_random_traffic();

		wait_for_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
